>>> hw/rtl/elab_pkg.sv
`timescale 1ns / 1ps
package elab_pkg;

  localparam int MaxNodes = 1024;
  localparam int MaxEdges = 4096;
  localparam int NodeW    = 10;
  localparam int EdgeAw   = 12;
  localparam int NbrAw    = 13;
  localparam int CntW     = 14;

  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_BUILD = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;
  localparam logic [1:0] ACT_FIND  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_NOT_BUILT = 2'd3;

  typedef struct packed {
    logic [CntW-1:0] deg;
    logic [CntW-1:0] off;
    logic [CntW-1:0] cur;
  } node_ent_t;

endpackage

>>> hw/rtl/elab_ram.sv
`timescale 1ns / 1ps
module elab_ram #(
  parameter int DW = elab_pkg::NodeW,
  parameter int AW = elab_pkg::NbrAw
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata_r
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

>>> hw/rtl/edge_list_to_adjacency_builder.sv
`timescale 1ns / 1ps
// Add goes straight to the result. Read fetches the node entry, then one list slot. Find scans
// the list entry by entry. Build clears all node entries, counts degrees, writes offsets
// and scatters each edge; the count and scatter steps are read-modify-writes on the node table.
// One item is in work at a time; the output register frees the input side once loaded.
// Reset (synchronous, active low) clears the edge count, id range, build flag and statistics;
// the memories are not cleared, a build rewrites all node entries first.
module edge_list_to_adjacency_builder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [9:0]  in_node_a,
  input  logic [9:0]  in_node_b,
  input  logic [12:0] in_slot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [12:0] out_value,
  output logic        out_found,
  output logic [13:0] out_degree,
  output logic [9:0]  out_highest_id,
  output logic [9:0]  out_lowest_id,
  output logic [10:0] out_vertex_count,
  output logic [12:0] out_edge_count,
  output logic [13:0] out_max_degree,
  output logic [1:0]  out_status
);

  localparam int NW = elab_pkg::NodeW;
  localparam int CW = elab_pkg::CntW;
  localparam int EW = 2 * elab_pkg::NodeW;
  localparam int XW = $bits(elab_pkg::node_ent_t);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CLR  = 5'd1;
  localparam logic [4:0] S_CE   = 5'd2;
  localparam logic [4:0] S_CA   = 5'd3;
  localparam logic [4:0] S_CAW  = 5'd4;
  localparam logic [4:0] S_CB   = 5'd5;
  localparam logic [4:0] S_CBW  = 5'd6;
  localparam logic [4:0] S_PR   = 5'd7;
  localparam logic [4:0] S_PW   = 5'd8;
  localparam logic [4:0] S_SE   = 5'd9;
  localparam logic [4:0] S_SA   = 5'd10;
  localparam logic [4:0] S_SAW  = 5'd11;
  localparam logic [4:0] S_SB   = 5'd12;
  localparam logic [4:0] S_SBW  = 5'd13;
  localparam logic [4:0] S_BD   = 5'd14;
  localparam logic [4:0] S_RS   = 5'd15;
  localparam logic [4:0] S_RV   = 5'd16;
  localparam logic [4:0] S_FS   = 5'd17;
  localparam logic [4:0] S_FR   = 5'd18;
  localparam logic [4:0] S_FC   = 5'd19;
  localparam logic [4:0] S_FIN  = 5'd20;
  localparam logic [4:0] S_BR   = 5'd21;

  logic [4:0]    state_r, state_nxt;
  logic [12:0]   edges_r;
  logic [12:0]   e_r;
  logic [NW-1:0] n_r;
  logic [CW-1:0] run_r, i_r, deg_r, off_r;
  logic [10:0]   vcnt_r;
  logic [CW-1:0] maxd_r;
  logic          built_r;
  logic [NW-1:0] hi_r, lo_r, a_r, b_r, ea_r, eb_r;
  logic [12:0]   slot_r;
  logic [12:0]   res_value_r;
  logic          res_found_r;
  logic [CW-1:0] res_degree_r;
  logic [1:0]    res_status_r;
  logic          out_valid_r;
  logic [12:0]   out_value_r, out_edge_count_r;
  logic          out_found_r;
  logic [CW-1:0] out_degree_r, out_max_degree_r;
  logic [NW-1:0] out_hi_r, out_lo_r;
  logic [10:0]   out_vcnt_r;
  logic [1:0]    out_status_r;

  logic          edge_we;
  logic [EW-1:0] edge_rdata;
  logic          node_we;
  logic [NW-1:0] node_waddr, node_raddr;
  elab_pkg::node_ent_t node_wdata, node_rd;
  logic [XW-1:0] node_rdata;
  logic          nbr_we;
  logic [12:0]   nbr_waddr, nbr_raddr;
  logic [NW-1:0] nbr_wdata, nbr_rdata;
  logic [CW-1:0] pos;
  logic          accept;

  assign node_rd  = elab_pkg::node_ent_t'(node_rdata);
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign pos      = node_rd.off + node_rd.cur;

  elab_ram #(.DW(EW), .AW(elab_pkg::EdgeAw)) u_edge (
    .clk(clk), .we(edge_we), .waddr(edges_r[elab_pkg::EdgeAw-1:0]),
    .wdata({in_node_a, in_node_b}), .raddr(e_r[elab_pkg::EdgeAw-1:0]), .rdata_r(edge_rdata)
  );

  elab_ram #(.DW(XW), .AW(NW)) u_node (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata_r(node_rdata)
  );

  elab_ram #(.DW(NW), .AW(elab_pkg::NbrAw)) u_nbr (
    .clk(clk), .we(nbr_we), .waddr(nbr_waddr), .wdata(nbr_wdata),
    .raddr(nbr_raddr), .rdata_r(nbr_rdata)
  );

  assign edge_we = accept && (in_action == elab_pkg::ACT_ADD) &&
                   (edges_r != 13'(elab_pkg::MaxEdges));

  always_comb begin
    node_we    = 1'b0;
    node_waddr = n_r;
    node_wdata = node_rd;
    node_raddr = in_node_a;
    nbr_we     = 1'b0;
    nbr_waddr  = pos[12:0];
    nbr_wdata  = eb_r;
    nbr_raddr  = 13'(off_r + slot_r);
    unique case (state_r)
      S_CLR: begin
        node_we    = 1'b1;
        node_wdata = '0;
      end
      S_CA, S_SA: node_raddr = edge_rdata[EW-1:NW];
      S_CAW: begin
        node_we        = 1'b1;
        node_waddr     = ea_r;
        node_wdata.deg = node_rd.deg + 1'b1;
      end
      S_CB, S_SB: node_raddr = eb_r;
      S_CBW: begin
        node_we        = 1'b1;
        node_waddr     = eb_r;
        node_wdata.deg = node_rd.deg + 1'b1;
      end
      S_PR: node_raddr = n_r;
      S_PW: begin
        node_we        = 1'b1;
        node_wdata.off = run_r;
        node_wdata.cur = '0;
      end
      S_SAW: begin
        node_we        = 1'b1;
        node_waddr     = ea_r;
        node_wdata.cur = node_rd.cur + 1'b1;
        nbr_we         = 1'b1;
      end
      S_SBW: begin
        node_we        = 1'b1;
        node_waddr     = eb_r;
        node_wdata.cur = node_rd.cur + 1'b1;
        nbr_we         = 1'b1;
        nbr_wdata      = ea_r;
      end
      S_BR: node_raddr = a_r;
      S_RS: nbr_raddr = 13'(node_rd.off + CW'(slot_r));
      S_FR: nbr_raddr = 13'(off_r + i_r);
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_action == elab_pkg::ACT_ADD) state_nxt = S_FIN;
          else if (in_action == elab_pkg::ACT_BUILD) state_nxt = S_CLR;
          else if (!built_r) state_nxt = S_FIN;
          else if (in_action == elab_pkg::ACT_READ) state_nxt = S_RS;
          else state_nxt = S_FS;
        end
      end
      S_CLR: if (n_r == NW'(elab_pkg::MaxNodes - 1)) state_nxt = S_CE;
      S_CE:  state_nxt = (e_r == edges_r) ? S_PR : S_CA;
      S_CA:  state_nxt = S_CAW;
      S_CAW: state_nxt = S_CB;
      S_CB:  state_nxt = S_CBW;
      S_CBW: state_nxt = S_CE;
      S_PR:  state_nxt = S_PW;
      S_PW:  state_nxt = (n_r == NW'(elab_pkg::MaxNodes - 1)) ? S_SE : S_PR;
      S_SE:  state_nxt = (e_r == edges_r) ? S_BR : S_SA;
      S_SA:  state_nxt = S_SAW;
      S_SAW: state_nxt = S_SB;
      S_SB:  state_nxt = S_SBW;
      S_SBW: state_nxt = S_SE;
      S_BR:  state_nxt = S_BD;
      S_BD:  state_nxt = S_FIN;
      S_RS:  state_nxt = (CW'(slot_r) < node_rd.deg) ? S_RV : S_FIN;
      S_RV:  state_nxt = S_FIN;
      S_FS: begin
        if ((edges_r != 0) && (a_r >= lo_r) && (a_r <= hi_r) && (node_rd.deg != 0)) begin
          state_nxt = S_FR;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FR:  state_nxt = S_FC;
      S_FC: begin
        if ((nbr_rdata == b_r) || (i_r + 1'b1 == deg_r)) state_nxt = S_FIN;
        else state_nxt = S_FR;
      end
      S_FIN: if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      edges_r     <= '0;
      built_r     <= 1'b0;
      hi_r        <= '0;
      lo_r        <= NW'(1023);
      vcnt_r      <= '0;
      maxd_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_FIN && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (edge_we) begin
        edges_r <= edges_r + 1'b1;
        built_r <= 1'b0;
        if (in_node_a > hi_r || in_node_b > hi_r) begin
          hi_r <= (in_node_a > in_node_b) ? in_node_a : in_node_b;
        end
        if (in_node_a < lo_r || in_node_b < lo_r) begin
          lo_r <= (in_node_a < in_node_b) ? in_node_a : in_node_b;
        end
      end
      if (accept && in_action == elab_pkg::ACT_BUILD) begin
        vcnt_r <= '0;
        maxd_r <= '0;
      end
      if (state_r == S_PW) begin
        if (node_rd.deg != 0) vcnt_r <= vcnt_r + 1'b1;
        if (node_rd.deg > maxd_r) maxd_r <= node_rd.deg;
      end
      if (state_r == S_BD) built_r <= 1'b1;
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        a_r          <= in_node_a;
        b_r          <= in_node_b;
        slot_r       <= in_slot;
        n_r          <= '0;
        e_r          <= '0;
        run_r        <= '0;
        res_value_r  <= '0;
        res_found_r  <= 1'b0;
        res_degree_r <= '0;
        res_status_r <= elab_pkg::ST_OK;
        if (in_action == elab_pkg::ACT_ADD) begin
          if (edges_r == 13'(elab_pkg::MaxEdges)) res_status_r <= elab_pkg::ST_FULL;
        end else if (in_action != elab_pkg::ACT_BUILD && !built_r) begin
          res_status_r <= elab_pkg::ST_NOT_BUILT;
        end
      end
      S_CLR: begin
        n_r <= n_r + 1'b1;
        e_r <= '0;
      end
      S_CA, S_SA: begin
        ea_r <= edge_rdata[EW-1:NW];
        eb_r <= edge_rdata[NW-1:0];
      end
      S_CBW, S_SBW: e_r <= e_r + 1'b1;
      S_PW: begin
        run_r <= run_r + node_rd.deg;
        n_r   <= n_r + 1'b1;
        e_r   <= '0;
      end
      S_BD: res_degree_r <= node_rd.deg;
      S_RS: begin
        res_degree_r <= node_rd.deg;
        if (!(CW'(slot_r) < node_rd.deg)) res_status_r <= elab_pkg::ST_RANGE;
      end
      S_RV: res_value_r <= 13'(nbr_rdata);
      S_FS: begin
        res_degree_r <= node_rd.deg;
        deg_r        <= node_rd.deg;
        off_r        <= node_rd.off;
        i_r          <= '0;
      end
      S_FC: begin
        if (nbr_rdata == b_r) begin
          res_found_r <= 1'b1;
          res_value_r <= i_r[12:0];
        end
        i_r <= i_r + 1'b1;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_value_r      <= res_value_r;
          out_found_r      <= res_found_r;
          out_degree_r     <= res_degree_r;
          out_hi_r         <= (edges_r != 0) ? hi_r : '0;
          out_lo_r         <= (edges_r != 0) ? lo_r : '0;
          out_vcnt_r       <= vcnt_r;
          out_edge_count_r <= edges_r;
          out_max_degree_r <= maxd_r;
          out_status_r     <= res_status_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_value        = out_value_r;
  assign out_found        = out_found_r;
  assign out_degree       = out_degree_r;
  assign out_highest_id   = out_hi_r;
  assign out_lowest_id    = out_lo_r;
  assign out_vertex_count = out_vcnt_r;
  assign out_edge_count   = out_edge_count_r;
  assign out_max_degree   = out_max_degree_r;
  assign out_status       = out_status_r;

endmodule
